// ----- design/sliding_window_mean_square_top_assert.svh -----
// ----------------------------------------------------------------------------
// Sliding-window mean square: assertion macros
// Concurrent checks that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEAN_SQUARE_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MEAN_SQUARE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define SWMS_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("swms check failed");

// next-cycle implication, checked outside reset
`define SWMS_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("swms check failed");

`else

`define SWMS_ASSERT_NOW(lbl, ck, rstn, ante, cons)
`define SWMS_ASSERT_NEXT(lbl, ck, rstn, ante, cons)

`endif

`endif

// ----- design/swms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window mean square: package
// Window geometry, data widths and the control group for the ring store.
// ----------------------------------------------------------------------------
package swms_pkg;

	localparam int WINDOW   = 128;
	localparam int SHIFT    = $clog2(WINDOW);
	localparam int POS_W    = (SHIFT < 1) ? 1 : SHIFT;
	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int SQ_W     = 31;
	localparam int SUM_W    = SQ_W + SHIFT;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;

	// largest value the running sum can reach: every slot at 2^30
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW) << (SQ_W - 1);

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ring_ctl_t;

endpackage

// ----- design/sliding_window_mean_square_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window mean square: top level
// Squares each signed sample and reports the mean of the last WINDOW squares.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while back-pressure does not stall the input and
// returns one mean square per sample. The first stage registers the window
// memory read (and the squarer), the second the running-sum update and output
// register. The window memory is read and written once per item on separate
// slots, so no interlock is needed. Slots not yet written since reset count
// as zero, so the first WINDOW results are the partial sum divided by WINDOW.
// Back-pressure on the output stalls the input only when both pipeline
// registers hold results.
module sliding_window_mean_square_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] sample (signed)
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [30:0] mean_square, [31] zero
);
	import swms_pkg::*;

	`include "sliding_window_mean_square_top_assert.svh"

	logic                 accept;
	logic                 out_free;
	logic [MAG_W-1:0]     mag;
	logic [2*MAG_W-1:0]   sq_full;
	logic                 valid_s1;
	logic [SQ_W-1:0]      sq_s1;
	logic [SQ_W-1:0]      old_sq;
	logic [SUM_W-1:0]     sum_q;
	logic [SUM_W-1:0]     sum_next;
	logic                 out_valid_q;
	logic [SQ_W-1:0]      mean_q;
	ring_ctl_t            ring_ctl;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign ring_ctl.rd_en = accept;
	assign ring_ctl.wr_en = valid_s1 && out_free;

	// magnitude of the two's complement code, up to 2^15
	assign mag = s_axis_tdata[SAMPLE_W-1]
		? (MAG_W'(1) << SAMPLE_W) - {1'b0, s_axis_tdata}
		: {1'b0, s_axis_tdata};
	assign sq_full = mag * mag;

	swms_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ring_ctl),
		.wr_data (sq_s1),
		.old_sq  (old_sq)
	);

	assign sum_next = sum_q - SUM_W'(old_sq) + SUM_W'(sq_s1);

	always_ff @(posedge clk) begin
		if (accept) begin
			sq_s1 <= sq_full[SQ_W-1:0];
		end
		if (valid_s1 && out_free) begin
			mean_q <= sum_next[SHIFT +: SQ_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			sum_q       <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (valid_s1 && out_free) begin
				sum_q <= sum_next;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - SQ_W){1'b0}}, mean_q};

	// the running sum never exceeds a full window of maximum squares
	`SWMS_ASSERT_NOW(a_sum_bound, clk, arst_n, 1'b1, sum_q <= SUM_MAX)
	// a result is at most 2^30
	`SWMS_ASSERT_NOW(a_mean_bound, clk, arst_n, out_valid_q,
		!(mean_q[SQ_W-1] && (|mean_q[SQ_W-2:0])))
	// with both stages full and the output stalled, the input must be held off
	`SWMS_ASSERT_NOW(a_full_stall, clk, arst_n,
		valid_s1 && out_valid_q && !m_axis_tready, !s_axis_tready)
	// a stage-one item meeting a free output is delivered next cycle
	`SWMS_ASSERT_NEXT(a_s1_moves, clk, arst_n, valid_s1 && out_free, out_valid_q)

endmodule

// ----- design/swms_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window mean square: ring store
// Window memory with its write pointer. A read fetches the slot the sample
// will replace; the write of the new square follows once wr_en is given.
// ----------------------------------------------------------------------------
module swms_ring (
	input  logic                   clk,
	input  logic                   arst_n,
	input  swms_pkg::ring_ctl_t    ctl,
	input  logic [swms_pkg::SQ_W-1:0] wr_data,
	output logic [swms_pkg::SQ_W-1:0] old_sq
);
	import swms_pkg::*;

	logic [SQ_W-1:0]  mem [WINDOW];
	logic [SQ_W-1:0]  rd_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] wr_pos_q;
	logic             wrapped_q;
	logic             old_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_pos_q] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[pos_q];
		end
	end

	// slots are filled in order, so a slot holds data once the pointer has wrapped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			wr_pos_q    <= '0;
			wrapped_q   <= 1'b0;
			old_valid_q <= 1'b0;
		end else if (ctl.rd_en) begin
			wr_pos_q    <= pos_q;
			old_valid_q <= wrapped_q;
			if (pos_q == POS_W'(WINDOW - 1)) begin
				pos_q     <= '0;
				wrapped_q <= 1'b1;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	assign old_sq = old_valid_q ? rd_q : '0;

endmodule
